>>> src/rsd_pkg.sv
// shared types, constants and palette table of the sprite row decoder
`timescale 1ns / 1ps

package rsd_pkg;

   localparam int FRAME_W   = 12;
   localparam int COL_W     = 13;
   localparam int BYTE_W    = 8;
   localparam int RUN_W     = 7;
   localparam int PAL_COUNT = 256;

   // configuration register indexes
   localparam logic CSR_FRAME_WIDTH = 1'b0;
   localparam logic CSR_RUN_MODE    = 1'b1;

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_LENGTH,
      PH_LITERAL,
      PH_RUNVAL
   } phase_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_width;
      logic               run_mode;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0]  x_start;
      logic [BYTE_W-1:0] span_length;
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] red;
      logic              row_done;
   } result_type;

   typedef logic [23:0] pal_rom_type [PAL_COUNT];

   // 0xRRGGBB, 6-bit components
   localparam pal_rom_type PAL_ROM = '{
      24'h000000, 24'h3f3f2f, 24'h3e3c08, 24'h3f3207, 24'h3f2905, 24'h3f1f03, 24'h3f1602, 24'h3f0c00,
      24'h000000, 24'h3f3f11, 24'h3f1514, 24'h132914, 24'h001d2f, 24'h3f3f33, 24'h3f3f32, 24'h3f3f35,
      24'h3f3f3f, 24'h3a3a3a, 24'h353535, 24'h303030, 24'h2b2b2b, 24'h262626, 24'h222222, 24'h1d1d1d,
      24'h191919, 24'h161616, 24'h121212, 24'h0e0e0e, 24'h0b0b0b, 24'h070707, 24'h030303, 24'h000000,
      24'h351b11, 24'h2e1911, 24'h271711, 24'h211512, 24'h1a1312, 24'h131013, 24'h0d0e13, 24'h060c13,
      24'h362d13, 24'h312913, 24'h2d2414, 24'h282015, 24'h231c15, 24'h1f1816, 24'h1a1417, 24'h150f17,
      24'h36363a, 24'h313237, 24'h2d2f33, 24'h292b30, 24'h24272d, 24'h202329, 24'h1b2026, 24'h171c23,
      24'h13181f, 24'h10151b, 24'h0d1116, 24'h0b0e12, 24'h080b0e, 24'h050709, 24'h030405, 24'h3e3c08,
      24'h001837, 24'h000c1c, 24'h3e3808, 24'h220802, 24'h002d03, 24'h001b02, 24'h3f3507, 24'h3f3106,
      24'h2d2c22, 24'h28271d, 24'h232218, 24'h1d1d12, 24'h17170f, 24'h11110b, 24'h0a0a07, 24'h050503,
      24'h363636, 24'h353232, 24'h322e2e, 24'h2e2a2a, 24'h2a2626, 24'h272222, 24'h231e1e, 24'h1f1a1a,
      24'h1d1717, 24'h1c1414, 24'h1a1111, 24'h180e0e, 24'h130a0a, 24'h0e0707, 24'h090404, 24'h3f2d06,
      24'h3f3f3a, 24'h3f3b32, 24'h3f2a05, 24'h3f2604, 24'h3f2f19, 24'h3f2b11, 24'h3f2708, 24'h3f2204,
      24'h381e00, 24'h321900, 24'h2b1500, 24'h241000, 24'h1e0b00, 24'h170600, 24'h100100, 24'h0a0000,
      24'h362f2c, 24'h332b28, 24'h312724, 24'h2e2320, 24'h2b1f1c, 24'h291c19, 24'h241917, 24'h1f1616,
      24'h1b1415, 24'h161113, 24'h110f12, 24'h0d0c11, 24'h0a0a0d, 24'h07070a, 24'h040406, 24'h010203,
      24'h353b36, 24'h2e3631, 24'h26302c, 24'h1f2a27, 24'h172422, 24'h101b1a, 24'h081112, 24'h010709,
      24'h3f322b, 24'h3a2b25, 24'h352420, 24'h2f1d1a, 24'h2a1615, 24'h241010, 24'h1c0a0c, 24'h160407,
      24'h37342a, 24'h323128, 24'h2d2e25, 24'h282b23, 24'h222821, 24'h1d251f, 24'h18221d, 24'h131f1a,
      24'h111b18, 24'h0f1815, 24'h0c1413, 24'h0a1110, 24'h070d0d, 24'h050a0b, 24'h030608, 24'h000305,
      24'h3f1e03, 24'h3f372a, 24'h3f3425, 24'h3f3220, 24'h362c20, 24'h2c271f, 24'h23211e, 24'h191c1e,
      24'h10161d, 24'h06111d, 24'h050f19, 24'h040c15, 24'h030a11, 24'h02070d, 24'h010509, 24'h3f1b03,
      24'h3d3733, 24'h3a352f, 24'h37322a, 24'h332f25, 24'h302c20, 24'h2c291b, 24'h292518, 24'h262216,
      24'h231e13, 24'h1f1a10, 24'h1a160e, 24'h16120b, 24'h120e08, 24'h0d0a05, 24'h090602, 24'h040100,
      24'h3f392e, 24'h3c3329, 24'h382d24, 24'h34261e, 24'h302019, 24'h2c1914, 24'h28130e, 24'h240d09,
      24'h210603, 24'h1d0503, 24'h190402, 24'h150402, 24'h110302, 24'h0d0201, 24'h090101, 24'h060101,
      24'h3f362c, 24'h3c3128, 24'h392d23, 24'h36291f, 24'h33241b, 24'h2f2016, 24'h2c1b12, 24'h2a1811,
      24'h281610, 24'h26130f, 24'h24100d, 24'h220d0c, 24'h1a0a0a, 24'h110808, 24'h080506, 24'h3f1702,
      24'h3f332f, 24'h3f302c, 24'h3f2d29, 24'h3e2a26, 24'h3e2723, 24'h3d2420, 24'h3d201e, 24'h3d1d1b,
      24'h3c1a18, 24'h3c1715, 24'h3b1412, 24'h3b110f, 24'h3b0e0c, 24'h3a0b0a, 24'h3a0707, 24'h390404,
      24'h390202, 24'h350202, 24'h310101, 24'h2e0101, 24'h2a0101, 24'h260101, 24'h220101, 24'h1e0101,
      24'h1b0101, 24'h170101, 24'h130101, 24'h3f1301, 24'h3f1001, 24'h080000, 24'h3f0c00, 24'h0c2e2b
   };

endpackage

>>> src/rsd_decode.sv
// span decoder: phase machine, column and counts, palette lookup
`timescale 1ns / 1ps

module rsd_decode (
   input  logic                       clock,
   input  logic                       reset,
   input  rsd_pkg::cfg_type           cfg,
   input  logic                       item_valid,
   input  logic [rsd_pkg::BYTE_W-1:0] data_byte,
   input  logic                       row_start,
   output logic                       res_valid,
   output rsd_pkg::result_type        res
);
   import rsd_pkg::*;

   phase_type          phase_ff, phase_in, phase_cur;
   logic [COL_W-1:0]   col_ff, col_in, col_cur, col_next;
   logic [BYTE_W-1:0]  lit_ff, lit_in, lit_cur, lit_dec, lit_len;
   logic [RUN_W-1:0]   run_ff, run_in, run_cur;
   logic [COL_W-1:0]   width_ext;
   logic [23:0]        pal;
   logic [BYTE_W-1:0]  blue_c, green_c, red_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         col_ff   <= '0;
         lit_ff   <= '0;
         run_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
         lit_ff   <= lit_in;
         run_ff   <= run_in;
      end
   end

   assign width_ext = {1'b0, cfg.frame_width};
   assign pal       = PAL_ROM[data_byte];
   assign blue_c    = {pal[5:0], 2'b00};
   assign green_c   = {pal[13:8], 2'b00};
   assign red_c     = {pal[21:16], 2'b00};
   assign lit_dec   = lit_cur - 8'd1;
   assign lit_len   = cfg.run_mode ? {1'b0, data_byte[7:1]} : data_byte;

   always_comb begin
      // row start clears the state before this byte is decoded
      phase_cur = row_start ? PH_SKIP : phase_ff;
      col_cur   = row_start ? '0 : col_ff;
      lit_cur   = row_start ? '0 : lit_ff;
      run_cur   = row_start ? '0 : run_ff;

      phase_in  = phase_ff;
      col_in    = col_ff;
      lit_in    = lit_ff;
      run_in    = run_ff;
      col_next  = '0;
      res_valid = 1'b0;
      res       = '0;

      if (item_valid) begin
         phase_in = phase_cur;
         col_in   = col_cur;
         lit_in   = lit_cur;
         run_in   = run_cur;
         case (phase_cur)
            PH_SKIP: begin
               col_next = col_cur + {{(COL_W-BYTE_W){1'b0}}, data_byte};
               // row already ended: byte is dropped
               if (col_cur < width_ext) begin
                  col_in = col_next;
                  if (col_next >= width_ext) begin
                     res_valid    = 1'b1;
                     res.x_start  = col_next;
                     res.row_done = 1'b1;
                  end else begin
                     phase_in = PH_LENGTH;
                  end
               end
            end
            PH_LENGTH: begin
               if (cfg.run_mode && data_byte[0]) begin
                  run_in   = data_byte[7:1];
                  phase_in = PH_RUNVAL;
               end else begin
                  lit_in   = lit_len;
                  phase_in = (lit_len != '0) ? PH_LITERAL : PH_SKIP;
               end
            end
            PH_LITERAL: begin
               col_next        = col_cur + {{(COL_W-1){1'b0}}, 1'b1};
               col_in          = col_next;
               lit_in          = lit_dec;
               res_valid       = 1'b1;
               res.x_start     = col_cur;
               res.span_length = 8'd1;
               res.blue        = blue_c;
               res.green       = green_c;
               res.red         = red_c;
               if (lit_dec == '0) begin
                  phase_in     = PH_SKIP;
                  res.row_done = (col_next >= width_ext);
               end
            end
            PH_RUNVAL: begin
               col_next = col_cur + {{(COL_W-RUN_W){1'b0}}, run_cur};
               phase_in = PH_SKIP;
               // zero-length run swallows its value byte
               if (run_cur != '0) begin
                  col_in          = col_next;
                  run_in          = '0;
                  res_valid       = 1'b1;
                  res.x_start     = col_cur;
                  res.span_length = {1'b0, run_cur};
                  res.blue        = blue_c;
                  res.green       = green_c;
                  res.red         = red_c;
                  res.row_done    = (col_next >= width_ext);
               end
            end
            default: begin
               phase_in = PH_SKIP;
            end
         endcase
      end
   end

endmodule

>>> src/rsd_out_buf.sv
// result register with one skid entry behind it
`timescale 1ns / 1ps

module rsd_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rsd_pkg::result_type push_data,
   input  logic                out_stall,
   output logic                out_valid,
   output rsd_pkg::result_type out_data,
   output logic                full
);
   import rsd_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       out_free;

   assign out_free = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff && !out_free;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign full      = skid_valid_ff;

endmodule

>>> src/rle_sprite_row_decoder.sv
// Transparent run-length sprite row decoder, top level.
//
// Encoded row bytes enter on the req_ channel, one byte per item, with
// req_row_start marking the first byte of a row. Each byte yields zero or
// one span on the rsp_ channel: start column, length, palette colour and a
// row-done flag. Both channels use valid/stall; an item moves on a clock
// edge where valid is high and stall is low.
// An accepted byte is held in the input register, then decode and palette
// lookup write its span into the result register that drives rsp_valid.
// One byte is taken every cycle while the result side keeps up; the decode
// loop closes through the phase, column and count registers. A skid entry
// behind the result register absorbs one span when rsp_stall rises; after
// that req_stall is raised until the skid entry drains.
// Registers frame_width (index 0) and run_mode (index 1) are written through
// csr_we/csr_index/csr_wdata and should only change while the block is idle.
// Synchronous reset clears the decoder to expect a skip byte at column 0,
// zeroes both registers and empties the pipeline.
`timescale 1ns / 1ps

module rle_sprite_row_decoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [rsd_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic                        req_row_start,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rsd_pkg::COL_W-1:0]   rsp_x_start,
   output logic [rsd_pkg::BYTE_W-1:0]  rsp_span_length,
   output logic [rsd_pkg::BYTE_W-1:0]  rsp_blue,
   output logic [rsd_pkg::BYTE_W-1:0]  rsp_green,
   output logic [rsd_pkg::BYTE_W-1:0]  rsp_red,
   output logic                        rsp_row_done,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [rsd_pkg::FRAME_W-1:0] csr_wdata
);
   import rsd_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_start_ff;
   logic              req_take, advance, buf_full, res_valid;
   result_type        res, out_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH: cfg_in.frame_width = csr_wdata;
            CSR_RUN_MODE:    cfg_in.run_mode    = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   assign advance     = in_valid_ff && !buf_full;
   assign req_stall   = in_valid_ff && buf_full;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= '0;
         in_valid_ff <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_row_start;
      end
   end

   rsd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (advance),
      .data_byte  (in_byte_ff),
      .row_start  (in_start_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   rsd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .full      (buf_full)
   );

   assign rsp_x_start     = out_data.x_start;
   assign rsp_span_length = out_data.span_length;
   assign rsp_blue        = out_data.blue;
   assign rsp_green       = out_data.green;
   assign rsp_red         = out_data.red;
   assign rsp_row_done    = out_data.row_done;

endmodule

>>> src/rsd_checker.sv
// port-level checks for the sprite row decoder and their bind
`timescale 1ns / 1ps

module rsd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [rsd_pkg::COL_W-1:0]   rsp_x_start,
   input logic [rsd_pkg::BYTE_W-1:0]  rsp_span_length,
   input logic [rsd_pkg::BYTE_W-1:0]  rsp_blue,
   input logic [rsd_pkg::BYTE_W-1:0]  rsp_green,
   input logic [rsd_pkg::BYTE_W-1:0]  rsp_red,
   input logic                        rsp_row_done
);
   import rsd_pkg::*;

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input only backs up behind a held result
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // a zero-length span is only the end-of-row notice
   a_notice_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_span_length == '0) |-> rsp_row_done)
      else $error("zero-length span without row done");

   a_notice_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_span_length == '0) |->
         (rsp_blue == '0 && rsp_green == '0 && rsp_red == '0))
      else $error("end-of-row notice carries a colour");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_x_start)
         && $stable(rsp_span_length) && $stable(rsp_row_done)))
      else $error("stalled result changed");

endmodule

bind rle_sprite_row_decoder rsd_checker u_rsd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_x_start     (rsp_x_start),
   .rsp_span_length (rsp_span_length),
   .rsp_blue        (rsp_blue),
   .rsp_green       (rsp_green),
   .rsp_red         (rsp_red),
   .rsp_row_done    (rsp_row_done)
);

>>> tb/sv/rle_sprite_row_decoder_chk.sv
// checker for the sprite row decoder: follows register writes, predicts spans and compares them
`timescale 1ns / 1ps

module rle_sprite_row_decoder_chk (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [rsd_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic                        req_row_start,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [rsd_pkg::COL_W-1:0]   rsp_x_start,
   input  logic [rsd_pkg::BYTE_W-1:0]  rsp_span_length,
   input  logic [rsd_pkg::BYTE_W-1:0]  rsp_blue,
   input  logic [rsd_pkg::BYTE_W-1:0]  rsp_green,
   input  logic [rsd_pkg::BYTE_W-1:0]  rsp_red,
   input  logic                        rsp_row_done,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [rsd_pkg::FRAME_W-1:0] csr_wdata,
   output int                          fail_count,
   output int                          spans_waiting,
   output int                          spans_seen
);

   rsd_pkg::cfg_type    cfg;
   rsd_pkg::phase_type  phase;
   logic [rsd_pkg::COL_W-1:0]  col;
   logic [rsd_pkg::BYTE_W-1:0] lit_left;
   logic [rsd_pkg::RUN_W-1:0]  run_len;
   rsd_pkg::result_type spans_due[$];
   int mismatches = 0;
   int checked = 0;

   assign fail_count = mismatches;
   assign spans_seen = checked;

   task automatic note_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         note_mismatch($sformatf("span %0d %s got %0d, want %0d", checked, name, got, want));
      end
   endtask

   function automatic rsd_pkg::result_type make_span(input logic [rsd_pkg::COL_W-1:0] x,
                                                      input logic [7:0] len,
                                                      input logic [7:0] idx,
                                                      input logic painted,
                                                      input logic done);
      logic [23:0] rgb;
      rsd_pkg::result_type s;
      rgb = painted ? rsd_pkg::PAL_ROM[idx] : 24'h0;
      s.x_start     = x;
      s.span_length = len;
      s.blue        = {rgb[5:0], 2'b00};
      s.green       = {rgb[13:8], 2'b00};
      s.red         = {rgb[21:16], 2'b00};
      s.row_done    = done;
      return s;
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic first);
      logic [rsd_pkg::COL_W-1:0] x;
      logic [rsd_pkg::COL_W-1:0] row_w;
      if (first) begin
         phase    = rsd_pkg::PH_SKIP;
         col      = '0;
         lit_left = '0;
         run_len  = '0;
      end
      row_w = {1'b0, cfg.frame_width};
      case (phase)
         rsd_pkg::PH_SKIP: begin
            // once the row has ended, bytes are dropped until the next row start
            if (col < row_w) begin
               col = col + {{(rsd_pkg::COL_W-8){1'b0}}, b};
               if (col >= row_w) begin
                  spans_due.push_back(make_span(col, 8'd0, 8'd0, 1'b0, 1'b1));
               end else begin
                  phase = rsd_pkg::PH_LENGTH;
               end
            end
         end
         rsd_pkg::PH_LENGTH: begin
            if (cfg.run_mode && b[0]) begin
               run_len = b[7:1];
               phase   = rsd_pkg::PH_RUNVAL;
            end else begin
               lit_left = cfg.run_mode ? {1'b0, b[7:1]} : b;
               phase    = (lit_left != 0) ? rsd_pkg::PH_LITERAL : rsd_pkg::PH_SKIP;
            end
         end
         rsd_pkg::PH_LITERAL: begin
            x        = col;
            col      = col + {{(rsd_pkg::COL_W-1){1'b0}}, 1'b1};
            lit_left = lit_left - 8'd1;
            if (lit_left == 0) begin
               phase = rsd_pkg::PH_SKIP;
               spans_due.push_back(make_span(x, 8'd1, b, 1'b1, col >= row_w));
            end else begin
               spans_due.push_back(make_span(x, 8'd1, b, 1'b1, 1'b0));
            end
         end
         default: begin
            phase = rsd_pkg::PH_SKIP;
            // a zero-length run swallows its value byte silently
            if (run_len != 0) begin
               x   = col;
               col = col + {{(rsd_pkg::COL_W-rsd_pkg::RUN_W){1'b0}}, run_len};
               spans_due.push_back(make_span(x, {1'b0, run_len}, b, 1'b1,
                                             col >= row_w));
               run_len = '0;
            end
         end
      endcase
   endtask

   task automatic check_span();
      rsd_pkg::result_type want;
      if (spans_due.size() == 0) begin
         note_mismatch($sformatf("span at x %0d with none expected", rsp_x_start));
      end else begin
         want = spans_due.pop_front();
         check_field("x_start", int'(rsp_x_start), int'(want.x_start));
         check_field("span_length", int'(rsp_span_length), int'(want.span_length));
         check_field("blue", int'(rsp_blue), int'(want.blue));
         check_field("green", int'(rsp_green), int'(want.green));
         check_field("red", int'(rsp_red), int'(want.red));
         check_field("row_done", int'(rsp_row_done), int'(want.row_done));
      end
      checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg      = '0;
         phase    = rsd_pkg::PH_SKIP;
         col      = '0;
         lit_left = '0;
         run_len  = '0;
         spans_due.delete();
      end else begin
         // a span leaving now always comes from an earlier item
         if (rsp_valid && !rsp_stall) begin
            check_span();
         end
         if (csr_we) begin
            if (csr_index == rsd_pkg::CSR_FRAME_WIDTH) begin
               cfg.frame_width = csr_wdata;
            end else begin
               cfg.run_mode = csr_wdata[0];
            end
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_data_byte, req_row_start);
         end
      end
      spans_waiting <= spans_due.size();
   end

endmodule

>>> tb/sv/rle_sprite_row_decoder_tb.sv
// testbench top: drives encoded rows, register settings and result stalls, gives the verdict
`timescale 1ns / 1ps

module rle_sprite_row_decoder_tb;

   logic                        clock;
   logic                        reset         = 1'b1;
   logic                        req_valid     = 1'b0;
   logic                        req_stall;
   logic [rsd_pkg::BYTE_W-1:0]  req_data_byte = '0;
   logic                        req_row_start = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall     = 1'b0;
   logic [rsd_pkg::COL_W-1:0]   rsp_x_start;
   logic [rsd_pkg::BYTE_W-1:0]  rsp_span_length;
   logic [rsd_pkg::BYTE_W-1:0]  rsp_blue;
   logic [rsd_pkg::BYTE_W-1:0]  rsp_green;
   logic [rsd_pkg::BYTE_W-1:0]  rsp_red;
   logic                        rsp_row_done;
   logic                        csr_we        = 1'b0;
   logic                        csr_index     = rsd_pkg::CSR_FRAME_WIDTH;
   logic [rsd_pkg::FRAME_W-1:0] csr_wdata     = '0;

   int fail_count;
   int spans_waiting;
   int spans_seen;
   int bytes_sent = 0;
   int settings_used = 0;
   int cur_width = 0;
   bit cur_run = 1'b0;
   bit calm = 1'b0;

   rle_sprite_row_decoder u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_row_start   (req_row_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_x_start     (rsp_x_start),
      .rsp_span_length (rsp_span_length),
      .rsp_blue        (rsp_blue),
      .rsp_green       (rsp_green),
      .rsp_red         (rsp_red),
      .rsp_row_done    (rsp_row_done),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   rle_sprite_row_decoder_chk u_chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_row_start   (req_row_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_x_start     (rsp_x_start),
      .rsp_span_length (rsp_span_length),
      .rsp_blue        (rsp_blue),
      .rsp_green       (rsp_green),
      .rsp_red         (rsp_red),
      .rsp_row_done    (rsp_row_done),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .spans_waiting   (spans_waiting),
      .spans_seen      (spans_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(99) < 8);
   end

   task automatic send_byte(input logic [7:0] b, input logic first, input bit counted);
      if (!calm && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_row_start <= first;
      do @(posedge clock); while (req_stall);
      if (counted) begin
         bytes_sent++;
      end
   endtask

   // hold the input until every predicted span is out, then leave the input
   // idle so that the pipeline clears
   task automatic drain_spans();
      req_valid <= 1'b0;
      do @(posedge clock); while (spans_waiting != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(input int w, input bit mode);
      csr_we    <= 1'b1;
      csr_index <= rsd_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= w[rsd_pkg::FRAME_W-1:0];
      @(posedge clock);
      csr_index <= rsd_pkg::CSR_RUN_MODE;
      csr_wdata <= {{(rsd_pkg::FRAME_W-1){1'b0}}, mode};
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_width = w;
      cur_run   = mode;
      settings_used++;
   endtask

   task automatic send_row(input bit cut_short);
      int col;
      int spans;
      int max_spans;
      int skip;
      int n;
      int k;
      bit first;
      col       = 0;
      spans     = 0;
      first     = 1'b1;
      max_spans = cut_short ? $urandom_range(0, 2) : 32'h7fff_ffff;
      while (col < cur_width && spans <= max_spans) begin
         if (cur_width > 300 || $urandom_range(9) == 0) begin
            skip = $urandom_range(0, 255);
         end else begin
            skip = $urandom_range(0, 5);
         end
         send_byte(skip[7:0], first, 1'b1);
         first = 1'b0;
         col += skip;
         if (col >= cur_width) begin
            break;
         end
         if (cur_run && $urandom_range(1) == 1) begin
            n = $urandom_range(0, cur_width > 300 ? 127 : 10);
            send_byte({n[6:0], 1'b1}, 1'b0, 1'b1);
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         end else begin
            if (!cur_run && $urandom_range(15) == 0) begin
               n = $urandom_range(0, 255);
            end else begin
               n = $urandom_range(0, 8);
            end
            send_byte(cur_run ? {n[6:0], 1'b0} : n[7:0], 1'b0, 1'b1);
            // a cut row may stop in the middle of a literal span
            k = cut_short ? $urandom_range(0, n) : n;
            repeat (k) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         end
         col += n;
         spans++;
      end
      // trailing bytes after the row end are dropped until the next row start
      if (col >= cur_width && $urandom_range(4) == 0) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
   endtask

   task automatic send_noise();
      repeat ($urandom_range(3, 10)) begin
         send_byte(8'($urandom_range(0, 255)), $urandom_range(9) == 0, 1'b1);
      end
   endtask

   initial begin
      int phase_no;
      int phase_end;
      int r;
      bit paused;
      phase_no = 0;
      paused   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // width zero after reset: the row has ended before it starts
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hff, 1'b0, 1'b0);
      drain_spans();

      // widest row, run mode: longest run, empty literal, empty run, short literal
      apply_setting(4095, 1'b1);
      send_byte(8'hff, 1'b1, 1'b1);
      send_byte(8'hff, 1'b0, 1'b1);
      send_byte(8'hff, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h01, 1'b0, 1'b1);
      send_byte(8'h80, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h04, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h01, 1'b0, 1'b1);
      drain_spans();

      // one-pixel row, literal only: end on a literal, bytes after the end,
      // skip past the end, and a row start in the middle of a literal span
      apply_setting(1, 1'b0);
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(8'h02, 1'b0, 1'b1);
      send_byte(8'h3f, 1'b0, 1'b1);
      send_byte(8'hfe, 1'b0, 1'b1);
      send_byte(8'h55, 1'b0, 1'b0);
      send_byte(8'h01, 1'b1, 1'b1);
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(8'h03, 1'b0, 1'b1);
      send_byte(8'h10, 1'b0, 1'b1);
      send_byte(8'h05, 1'b1, 1'b1);
      send_byte(8'hff, 1'b1, 1'b1);

      while (bytes_sent < 450) begin
         drain_spans();
         case (phase_no % 5)
            0: apply_setting($urandom_range(2, 40), phase_no[0]);
            1: apply_setting(4095, phase_no[0]);
            2: apply_setting(1, phase_no[0]);
            3: apply_setting($urandom_range(41, 300), phase_no[0]);
            default: apply_setting($urandom_range(2, 16), phase_no[0]);
         endcase
         phase_end = bytes_sent + 80;
         while (bytes_sent < phase_end && bytes_sent < 450) begin
            calm = (bytes_sent >= 120 && bytes_sent < 220);
            if (!paused && bytes_sent >= 250) begin
               drain_spans();
               paused = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 10) begin
               send_noise();
            end else begin
               send_row(r < 20);
            end
         end
         phase_no++;
      end
      calm = 1'b0;

      drain_spans();
      $display("run covered %0d row bytes under %0d register settings", bytes_sent,
               settings_used);
      $display("%0d spans compared field by field", spans_seen);
      if (fail_count == 0 && spans_waiting == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
